// ===== design/edit_distance_best_match_assert.svh =====
`ifndef EDIT_DISTANCE_BEST_MATCH_ASSERT_SVH
`define EDIT_DISTANCE_BEST_MATCH_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold.
`define EDBM_ASSERT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define EDBM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/edbm_pkg.sv =====
package edbm_pkg;

    localparam int MAX_LEN  = 32;
    localparam int DP_DEPTH = MAX_LEN + 1;
    localparam int IDX_W    = $clog2(DP_DEPTH);
    localparam int TA_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CH_W     = 8;
    localparam int DIST_W   = 8;
    localparam int CNT_W    = 16;
    localparam int OP_W     = 2;

    localparam logic [OP_W-1:0] OP_TARGET = 2'd0;
    localparam logic [OP_W-1:0] OP_CAND   = 2'd1;
    localparam logic [OP_W-1:0] OP_END    = 2'd2;
    localparam logic [OP_W-1:0] OP_NEW    = 2'd3;

    typedef struct packed {
        logic              re;
        logic [IDX_W-1:0]  addr;
    } dp_rd_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  addr;
        logic [DIST_W-1:0] data;
    } dp_wr_t;

    typedef struct packed {
        logic             we;
        logic [TA_W-1:0]  waddr;
        logic [CH_W-1:0]  wdata;
        logic [TA_W-1:0]  raddr;
    } tgt_acc_t;

    // First member lands in the upper bits, so the lowest output field is last.
    typedef struct packed {
        logic              target_overflow;
        logic [DIST_W-1:0] best_distance;
        logic [CNT_W-1:0]  best_index;
        logic              best_found;
        logic [DIST_W-1:0] distance;
        logic [CNT_W-1:0]  cand_index;
    } result_t;

    localparam int RES_W = $bits(result_t);
    localparam int OUT_W = ((RES_W + 7) / 8) * 8;

    function automatic logic [DIST_W-1:0] sat_inc(input logic [DIST_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [DIST_W-1:0] min2(input logic [DIST_W-1:0] a,
                                               input logic [DIST_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

endpackage

// ===== design/edit_distance_best_match.sv =====
// Levenshtein best-match search; one transaction on s_ is one operation.
// Target char and new search finish in idle; a candidate char sweeps the dp row (ROW, DRAIN),
// the walk over the dp row memory going one entry per cycle through its single read port.
// End of candidate: END_RD reads, END_CMP compares (waiting while m_ stalls) and loads m_.
// aresetn is synchronous, active low: max_distance returns to 2, search state clears and
// the dp row reads back entry j as j at once through per-entry valid flags (no clearing pass).
`include "edit_distance_best_match_assert.svh"

module edit_distance_best_match (
    input  logic                          aclk,
    input  logic                          aresetn,

    // Configuration: max_distance write channel, always ready.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [edbm_pkg::DIST_W-1:0]   cfg_data,    // [7:0] max_distance

    // Input items.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [edbm_pkg::CH_W-1:0]     s_tdata,     // [7:0] ch
    input  logic [edbm_pkg::OP_W-1:0]     s_tuser,     // [1:0] op

    // Results, one per end-of-candidate transaction.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [15:0] cand_index, [23:16] distance, [24] best_found, [40:25] best_index,
    // [48:41] best_distance, [49] target_overflow, [55:50] zero
    output logic [edbm_pkg::OUT_W-1:0]    m_tdata
);
    import edbm_pkg::*;

    logic [DIST_W-1:0] max_dist_reg, max_dist_next;
    logic              m_valid_reg, m_valid_next;
    result_t           m_data_reg, m_data_next;

    logic              out_free;
    logic              res_push;
    result_t           res;
    dp_rd_t            dp_rd;
    dp_wr_t            dp_wr;
    logic              dp_clr;
    logic [DIST_W-1:0] dp_rdata;
    tgt_acc_t          tgt_acc;
    logic [CH_W-1:0]   tgt_rdata;

    // Config register: take every write; the sequencer reads it at end of candidate.
    assign cfg_ready     = 1'b1;
    assign max_dist_next = (cfg_valid && cfg_ready) ? cfg_data : max_dist_reg;

    // Output register: the sequencer may load it whenever it is empty or being drained,
    // so the next input is accepted while a result still waits on m_.
    assign out_free     = !m_valid_reg || m_tready;
    assign m_valid_next = res_push ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    assign m_data_next  = res_push ? res : m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_dist_reg <= DIST_W'(2);
            m_valid_reg  <= 1'b0;
        end else begin
            max_dist_reg <= max_dist_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Hold the payload; no reset needed.
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_W - RES_W){1'b0}}, m_data_reg};

    // Sequencer: target load, row sweep, end-of-candidate compare and best-match state.
    edbm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_ch     (s_tdata),
        .max_dist  (max_dist_reg),
        .out_free  (out_free),
        .res_push  (res_push),
        .res       (res),
        .dp_rd     (dp_rd),
        .dp_wr     (dp_wr),
        .dp_clr    (dp_clr),
        .dp_rdata  (dp_rdata),
        .tgt_acc   (tgt_acc),
        .tgt_rdata (tgt_rdata)
    );

    // dp row memory, MAX_LEN + 1 entries, registered read.
    edbm_dp_ram u_dp_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clr     (dp_clr),
        .rd      (dp_rd),
        .wr      (dp_wr),
        .rdata   (dp_rdata)
    );

    // Target string memory, MAX_LEN entries, registered read.
    edbm_tgt_ram u_tgt_ram (
        .aclk  (aclk),
        .acc   (tgt_acc),
        .rdata (tgt_rdata)
    );

    `EDBM_ASSERT(a_no_drop, aclk, aresetn, res_push, !m_valid_reg || m_tready,
                 "result loaded over an undelivered one")
    `EDBM_ASSERT_NEXT(a_push_shows, aclk, aresetn, res_push, m_tvalid,
                      "loaded result not presented")
    `EDBM_ASSERT(a_busy_no_take, aclk, aresetn, m_valid_reg && !m_tready,
                 !res_push, "result pushed while output stalled")

endmodule

// ===== design/edbm_dp_ram.sv =====
`include "edit_distance_best_match_assert.svh"

module edbm_dp_ram (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          clr,
    input  edbm_pkg::dp_rd_t              rd,
    input  edbm_pkg::dp_wr_t              wr,
    output logic [edbm_pkg::DIST_W-1:0]   rdata
);
    import edbm_pkg::*;

    logic [DIST_W-1:0]   mem [DP_DEPTH];
    logic [DP_DEPTH-1:0] valid_reg;
    logic [DP_DEPTH-1:0] valid_next;
    logic [DIST_W-1:0]   rdata_reg;

    // An entry not written since the last restart reads back its own index.
    always_comb begin
        valid_next = valid_reg;
        if (clr) begin
            valid_next = '0;
        end else if (wr.we) begin
            valid_next[wr.addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.re) begin
            rdata_reg <= valid_reg[rd.addr] ? mem[rd.addr] : DIST_W'(rd.addr);
        end
    end

    assign rdata = rdata_reg;

    `EDBM_ASSERT(a_clr_no_write, aclk, aresetn, clr, !wr.we, "dp row cleared during a write")
    `EDBM_ASSERT(a_wr_in_range, aclk, aresetn, wr.we, wr.addr < IDX_W'(DP_DEPTH),
                 "dp row write out of range")
    `EDBM_ASSERT(a_rd_in_range, aclk, aresetn, rd.re, rd.addr < IDX_W'(DP_DEPTH),
                 "dp row read out of range")

endmodule

// ===== design/edbm_tgt_ram.sv =====
module edbm_tgt_ram (
    input  logic                        aclk,
    input  edbm_pkg::tgt_acc_t          acc,
    output logic [edbm_pkg::CH_W-1:0]   rdata
);
    import edbm_pkg::*;

    logic [CH_W-1:0] mem [MAX_LEN];
    logic [CH_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (acc.we) begin
            mem[acc.waddr] <= acc.wdata;
        end
        rdata_reg <= mem[acc.raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/edbm_ctrl.sv =====
`include "edit_distance_best_match_assert.svh"

module edbm_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [edbm_pkg::OP_W-1:0]     in_op,
    input  logic [edbm_pkg::CH_W-1:0]     in_ch,
    input  logic [edbm_pkg::DIST_W-1:0]   max_dist,
    input  logic                          out_free,
    output logic                          res_push,
    output edbm_pkg::result_t             res,
    output edbm_pkg::dp_rd_t              dp_rd,
    output edbm_pkg::dp_wr_t              dp_wr,
    output logic                          dp_clr,
    input  logic [edbm_pkg::DIST_W-1:0]   dp_rdata,
    output edbm_pkg::tgt_acc_t            tgt_acc,
    input  logic [edbm_pkg::CH_W-1:0]     tgt_rdata
);
    import edbm_pkg::*;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_ROW     = 3'd1;
    localparam logic [2:0] ST_DRAIN   = 3'd2;
    localparam logic [2:0] ST_END_RD  = 3'd3;
    localparam logic [2:0] ST_END_CMP = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic              p_vld_reg, p_vld_next;
    logic [IDX_W-1:0]  tlen_reg, tlen_next;
    logic [DIST_W-1:0] cand_len_reg, cand_len_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              best_vld_reg, best_vld_next;
    logic [CNT_W-1:0]  best_idx_reg, best_idx_next;
    logic [DIST_W-1:0] best_dist_reg, best_dist_next;
    logic              ovf_reg, ovf_next;

    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  p_j_reg, p_j_next;
    logic [DIST_W-1:0] left_reg, left_next;
    logic [DIST_W-1:0] diag_reg, diag_next;
    logic [CH_W-1:0]   ch_reg, ch_next;

    logic              accept;
    logic [DIST_W-1:0] sub_cost;
    logic [DIST_W-1:0] cell_val;
    logic [DIST_W-1:0] new_val;
    logic              take;
    logic              nb_vld;
    logic [CNT_W-1:0]  nb_idx;
    logic [DIST_W-1:0] nb_dist;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // Row sweep reads entry idx; the read of the last entry stays put for the end compare.
    assign dp_rd.re   = (state_reg == ST_ROW) || (state_reg == ST_END_RD);
    assign dp_rd.addr = (state_reg == ST_ROW) ? idx_reg : tlen_reg;

    // One cell of the row, in the cycle after its read was issued.
    assign sub_cost = (tgt_rdata == ch_reg) ? diag_reg : sat_inc(diag_reg);
    assign cell_val = min2(min2(sat_inc(dp_rdata), sat_inc(left_reg)), sub_cost);
    assign new_val  = (p_j_reg == '0) ? cand_len_reg : cell_val;

    assign dp_wr.we   = p_vld_reg;
    assign dp_wr.addr = p_j_reg;
    assign dp_wr.data = new_val;

    // Best-match update at end of candidate.
    assign take    = (dp_rdata <= max_dist) && (!best_vld_reg || (dp_rdata < best_dist_reg));
    assign nb_vld  = best_vld_reg || take;
    assign nb_idx  = take ? cnt_reg : best_idx_reg;
    assign nb_dist = take ? dp_rdata : best_dist_reg;

    assign res.cand_index      = cnt_reg;
    assign res.distance        = dp_rdata;
    assign res.best_found      = nb_vld;
    assign res.best_index      = nb_vld ? nb_idx : '0;
    assign res.best_distance   = nb_vld ? nb_dist : '0;
    assign res.target_overflow = ovf_reg;

    assign res_push = (state_reg == ST_END_CMP) && out_free;

    always_comb begin
        state_next     = state_reg;
        p_vld_next     = 1'b0;
        tlen_next      = tlen_reg;
        cand_len_next  = cand_len_reg;
        cnt_next       = cnt_reg;
        best_vld_next  = best_vld_reg;
        best_idx_next  = best_idx_reg;
        best_dist_next = best_dist_reg;
        ovf_next       = ovf_reg;
        idx_next       = idx_reg;
        p_j_next       = p_j_reg;
        left_next      = left_reg;
        diag_next      = diag_reg;
        ch_next        = ch_reg;
        dp_clr         = 1'b0;
        tgt_acc.we     = 1'b0;
        tgt_acc.waddr  = TA_W'(tlen_reg);
        tgt_acc.wdata  = in_ch;
        tgt_acc.raddr  = TA_W'(idx_reg - 1'b1);

        if (p_vld_reg) begin
            left_next = new_val;
            diag_next = dp_rdata;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (in_op)
                        OP_TARGET: begin
                            if (tlen_reg < IDX_W'(MAX_LEN)) begin
                                tgt_acc.we = 1'b1;
                                tlen_next  = tlen_reg + 1'b1;
                            end else begin
                                ovf_next = 1'b1;
                            end
                            dp_clr        = 1'b1;
                            cand_len_next = '0;
                        end
                        OP_CAND: begin
                            cand_len_next = sat_inc(cand_len_reg);
                            ch_next       = in_ch;
                            idx_next      = '0;
                            state_next    = ST_ROW;
                        end
                        OP_END: begin
                            state_next = ST_END_RD;
                        end
                        OP_NEW: begin
                            tlen_next      = '0;
                            cnt_next       = '0;
                            best_vld_next  = 1'b0;
                            best_idx_next  = '0;
                            best_dist_next = '0;
                            ovf_next       = 1'b0;
                            cand_len_next  = '0;
                            dp_clr         = 1'b1;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ROW: begin
                p_vld_next = 1'b1;
                p_j_next   = idx_reg;
                if (idx_reg == tlen_reg) begin
                    state_next = ST_DRAIN;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                state_next = ST_IDLE;
            end
            ST_END_RD: begin
                state_next = ST_END_CMP;
            end
            ST_END_CMP: begin
                if (out_free) begin
                    best_vld_next  = nb_vld;
                    best_idx_next  = nb_idx;
                    best_dist_next = nb_dist;
                    cnt_next       = cnt_reg + 1'b1;
                    cand_len_next  = '0;
                    dp_clr         = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            p_vld_reg     <= 1'b0;
            tlen_reg      <= '0;
            cand_len_reg  <= '0;
            cnt_reg       <= '0;
            best_vld_reg  <= 1'b0;
            best_idx_reg  <= '0;
            best_dist_reg <= '0;
            ovf_reg       <= 1'b0;
        end else begin
            state_reg     <= state_next;
            p_vld_reg     <= p_vld_next;
            tlen_reg      <= tlen_next;
            cand_len_reg  <= cand_len_next;
            cnt_reg       <= cnt_next;
            best_vld_reg  <= best_vld_next;
            best_idx_reg  <= best_idx_next;
            best_dist_reg <= best_dist_next;
            ovf_reg       <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg  <= idx_next;
        p_j_reg  <= p_j_next;
        left_reg <= left_next;
        diag_reg <= diag_next;
        ch_reg   <= ch_next;
    end

    `EDBM_ASSERT(a_dp_no_collide, aclk, aresetn, dp_wr.we && dp_rd.re,
                 dp_wr.addr != dp_rd.addr, "dp row read and write hit the same entry")
    `EDBM_ASSERT(a_tlen_bound, aclk, aresetn, 1'b1, tlen_reg <= IDX_W'(MAX_LEN),
                 "target length beyond maximum")
    `EDBM_ASSERT(a_wr_in_sweep, aclk, aresetn, dp_wr.we,
                 (state_reg == ST_ROW) || (state_reg == ST_DRAIN),
                 "dp row written outside a row sweep")
    `EDBM_ASSERT_NEXT(a_push_restart, aclk, aresetn, res_push,
                      (state_reg == ST_IDLE) && (cand_len_reg == '0),
                      "candidate not restarted after result")

endmodule
